// ===== hw/rtl/pfr_pkg.sv =====
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared sizes, types and control codes of the Pareto front ranker.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  localparam int POP_SIZE  = 64;
  localparam int IDX_W     = $clog2(POP_SIZE);
  localparam int CNT_W     = IDX_W + 1;
  localparam int NUM_OBJ   = 4;
  localparam int OBJ_W     = 32;
  localparam int OBJ_CNT_W = 3;
  localparam int RANK_W    = 7;
  localparam int NUM_LANES = 8;
  localparam int LANE_W    = $clog2(NUM_LANES);
  localparam int BLK_W     = IDX_W - LANE_W;

  typedef logic signed [OBJ_W-1:0] obj_t;
  typedef obj_t [NUM_OBJ-1:0]      obj_vec_t;
  typedef logic [POP_SIZE-1:0]     pop_mask_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [RANK_W-1:0]       rank_t;
  typedef logic [OBJ_CNT_W-1:0]    obj_cnt_t;
  typedef logic [LANE_W-1:0]       lane_t;
  typedef logic [BLK_W-1:0]        blk_t;

  // Per-lane control from the sequencer
  typedef struct packed {
    logic tgt_we;   // capture the streamed individual as this lane's target
    logic row_clr;  // clear the accumulated dominator row
    logic cmp_en;   // compare streamed individual against the target
    idx_t cmp_idx;  // load position of the streamed individual
  } lane_ctl_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_TGT,
    ST_CMP,
    ST_CMP_END,
    ST_ROWS,
    ST_PEEL,
    ST_PEEL_WAIT,
    ST_PEEL_END,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_EMIT_WAIT
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfr_ram.sv =====
// ----------------------------------------------------------------------------
// pfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_lane.sv =====
// ----------------------------------------------------------------------------
// pfr_lane
// One dominance lane: holds a target individual and builds its row of
// dominators while the population streams past.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_lane import pfr_pkg::*; (
  input  wire logic      clk,
  input  wire lane_ctl_t ctl,
  input  wire obj_vec_t  obj,
  input  wire obj_cnt_t  k,
  output pop_mask_t      row
);

  obj_vec_t  tgt_r;
  pop_mask_t row_r;

  // a dominates b: no active objective worse, at least one strictly better
  function automatic logic dominates(obj_vec_t a, obj_vec_t b, obj_cnt_t kk);
    logic le_all;
    logic lt_any;
    le_all = 1'b1;
    lt_any = 1'b0;
    for (int o = 0; o < NUM_OBJ; o++) begin
      if (OBJ_CNT_W'(o) < kk) begin
        if ($signed(a[o]) > $signed(b[o])) le_all = 1'b0;
        if ($signed(a[o]) < $signed(b[o])) lt_any = 1'b1;
      end
    end
    return le_all && lt_any;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.tgt_we) begin
      tgt_r <= obj;
    end
    if (ctl.row_clr) begin
      row_r <= '0;
    end else if (ctl.cmp_en) begin
      row_r[ctl.cmp_idx] <= dominates(obj, tgt_r, k);
    end
  end

  assign row = row_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pareto_front_ranker_core.sv =====
// ----------------------------------------------------------------------------
// pareto_front_ranker_core
// Pareto non-dominated sorting of up to 64 individuals with 8 dominance lanes
// and front-by-front peeling over a stored dominator matrix.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | objective_a..d, final_individual
//  out     | output    | out_valid/out_stall| index, rank, overflow, last
//  cfg     | input     | cfg_write_en       | objectives_used (3 bits)
//
//  Loading takes one transaction per cycle. After the final one, with n loaded:
//  ceil(n/8) blocks of eight targets in the lanes, each streaming the population
//  through the single objective RAM read port, then one sweep per front, one
//  matrix row read a cycle, then one result at a time, each held until taken.
//  in_stall is high from the final transaction until the last result is taken.
//  Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module pareto_front_ranker_core import pfr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [31:0]   in_objective_a,
  input  wire logic signed [31:0]   in_objective_b,
  input  wire logic signed [31:0]   in_objective_c,
  input  wire logic signed [31:0]   in_objective_d,
  input  wire logic                 in_final_individual,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [IDX_W-1:0]          out_individual_index,
  output logic [RANK_W-1:0]         out_front_rank,
  output logic                      out_overflow_seen,
  output logic                      out_last_result,
  input  wire logic                 cfg_write_en,
  input  wire logic [OBJ_CNT_W-1:0] cfg_write_data
);

  state_t    state_r, state_nxt;
  idx_t      seq_r, seq_nxt;
  blk_t      blk_r, blk_nxt;
  cnt_t      load_cnt_r, load_cnt_nxt;
  logic      ovf_r, ovf_nxt;
  rank_t     round_r, round_nxt;
  pop_mask_t done_r, done_nxt;
  pop_mask_t front_r, front_nxt;
  cnt_t      ranked_r, ranked_nxt;
  obj_cnt_t  k_act_r;
  logic      out_vld_r, out_vld_nxt;

  logic      tv_d_r;
  lane_t     tl_d_r;
  logic      cv_d_r;
  idx_t      ci_d_r;
  logic      pv_d_r;
  idx_t      pj_d_r;

  idx_t      out_idx_r;
  rank_t     out_rank_r;
  logic      out_ovf_r;
  logic      out_last_r;

  logic      in_acc;
  logic      obj_we;
  obj_vec_t  obj_wdata;
  obj_vec_t  obj_rdata;
  idx_t      obj_raddr;
  idx_t      blk_addr;
  pop_mask_t mx_rdata;
  rank_t     rk_rdata;
  cnt_t      n_last;
  logic      seq_is_last;
  logic      lane_is_last;
  logic      blk_is_last;
  logic      peel_hit;

  lane_ctl_t lane_ctl [NUM_LANES];
  pop_mask_t lane_row [NUM_LANES];

  assign in_stall     = (state_r != ST_LOAD);
  assign in_acc       = in_valid && !in_stall;
  assign obj_we       = in_acc && (load_cnt_r < CNT_W'(POP_SIZE));
  assign obj_wdata    = {in_objective_d, in_objective_c, in_objective_b, in_objective_a};
  assign blk_addr     = {blk_r, seq_r[LANE_W-1:0]};
  assign obj_raddr    = (state_r == ST_TGT) ? blk_addr : seq_r;
  assign n_last       = load_cnt_r - cnt_t'(1);
  assign seq_is_last  = ({1'b0, seq_r} == n_last);
  assign lane_is_last = (seq_r[LANE_W-1:0] == lane_t'(NUM_LANES - 1));
  assign blk_is_last  = (blk_r == n_last[IDX_W-1:LANE_W]);
  // Front member: not yet ranked and every dominator already ranked earlier
  assign peel_hit     = pv_d_r && !done_r[pj_d_r] && ((mx_rdata & ~done_r) == '0);

  pfr_ram #(.WIDTH($bits(obj_vec_t)), .DEPTH(POP_SIZE)) u_obj_ram (
    .clk     (clk),
    .wr_en   (obj_we),
    .wr_addr (load_cnt_r[IDX_W-1:0]),
    .wr_data (obj_wdata),
    .rd_addr (obj_raddr),
    .rd_data (obj_rdata)
  );

  // Row j holds the set of individuals that dominate j
  pfr_ram #(.WIDTH(POP_SIZE), .DEPTH(POP_SIZE)) u_mx_ram (
    .clk     (clk),
    .wr_en   (state_r == ST_ROWS),
    .wr_addr (blk_addr),
    .wr_data (lane_row[seq_r[LANE_W-1:0]]),
    .rd_addr (seq_r),
    .rd_data (mx_rdata)
  );

  pfr_ram #(.WIDTH(RANK_W), .DEPTH(POP_SIZE)) u_rank_ram (
    .clk     (clk),
    .wr_en   (peel_hit),
    .wr_addr (pj_d_r),
    .wr_data (round_r),
    .rd_addr (seq_r),
    .rd_data (rk_rdata)
  );

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_ctl[l].tgt_we  = tv_d_r && (tl_d_r == lane_t'(l));
      lane_ctl[l].row_clr = (state_r == ST_TGT);
      lane_ctl[l].cmp_en  = cv_d_r;
      lane_ctl[l].cmp_idx = ci_d_r;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    pfr_lane u_lane (
      .clk (clk),
      .ctl (lane_ctl[g]),
      .obj (obj_rdata),
      .k   (k_act_r),
      .row (lane_row[g])
    );
  end

  always_comb begin
    state_nxt    = state_r;
    seq_nxt      = seq_r;
    blk_nxt      = blk_r;
    load_cnt_nxt = load_cnt_r;
    ovf_nxt      = ovf_r;
    round_nxt    = round_r;
    done_nxt     = done_r;
    front_nxt    = front_r;
    ranked_nxt   = ranked_r;
    out_vld_nxt  = out_vld_r;

    if (peel_hit) begin
      front_nxt[pj_d_r] = 1'b1;
      ranked_nxt        = ranked_r + cnt_t'(1);
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (obj_we) begin
            load_cnt_nxt = load_cnt_r + cnt_t'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_individual) begin
            state_nxt = ST_TGT;
            seq_nxt   = '0;
            blk_nxt   = '0;
          end
        end
      end
      ST_TGT: begin
        seq_nxt = seq_r + idx_t'(1);
        if (lane_is_last) begin
          seq_nxt   = '0;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        seq_nxt = seq_r + idx_t'(1);
        if (seq_is_last) begin
          seq_nxt   = '0;
          state_nxt = ST_CMP_END;
        end
      end
      ST_CMP_END: begin
        state_nxt = ST_ROWS;
      end
      ST_ROWS: begin
        seq_nxt = seq_r + idx_t'(1);
        if (lane_is_last) begin
          seq_nxt = '0;
          if (blk_is_last) begin
            state_nxt  = ST_PEEL;
            done_nxt   = '0;
            front_nxt  = '0;
            round_nxt  = rank_t'(1);
            ranked_nxt = '0;
          end else begin
            blk_nxt   = blk_r + BLK_W'(1);
            state_nxt = ST_TGT;
          end
        end
      end
      ST_PEEL: begin
        seq_nxt = seq_r + idx_t'(1);
        if (seq_is_last) begin
          seq_nxt   = '0;
          state_nxt = ST_PEEL_WAIT;
        end
      end
      ST_PEEL_WAIT: begin
        state_nxt = ST_PEEL_END;
      end
      ST_PEEL_END: begin
        // retire this front, then either sweep again or start emitting
        done_nxt  = done_r | front_r;
        front_nxt = '0;
        if (ranked_r == load_cnt_r) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          round_nxt = round_r + rank_t'(1);
          state_nxt = ST_PEEL;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_CAP;
      end
      ST_EMIT_CAP: begin
        out_vld_nxt = 1'b1;
        state_nxt   = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (!out_stall) begin
          out_vld_nxt = 1'b0;
          if (seq_is_last) begin
            seq_nxt      = '0;
            load_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            state_nxt    = ST_LOAD;
          end else begin
            seq_nxt   = seq_r + idx_t'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      seq_r      <= '0;
      blk_r      <= '0;
      load_cnt_r <= '0;
      ovf_r      <= 1'b0;
      round_r    <= '0;
      done_r     <= '0;
      front_r    <= '0;
      ranked_r   <= '0;
      k_act_r    <= obj_cnt_t'(NUM_OBJ);
      out_vld_r  <= 1'b0;
      tv_d_r     <= 1'b0;
      cv_d_r     <= 1'b0;
      pv_d_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      seq_r      <= seq_nxt;
      blk_r      <= blk_nxt;
      load_cnt_r <= load_cnt_nxt;
      ovf_r      <= ovf_nxt;
      round_r    <= round_nxt;
      done_r     <= done_nxt;
      front_r    <= front_nxt;
      ranked_r   <= ranked_nxt;
      out_vld_r  <= out_vld_nxt;
      tv_d_r     <= (state_r == ST_TGT);
      cv_d_r     <= (state_r == ST_CMP);
      pv_d_r     <= (state_r == ST_PEEL);
      if (cfg_write_en) begin
        // clamp the objective count to 1..NUM_OBJ
        if (cfg_write_data == '0) begin
          k_act_r <= obj_cnt_t'(1);
        end else if (cfg_write_data > obj_cnt_t'(NUM_OBJ)) begin
          k_act_r <= obj_cnt_t'(NUM_OBJ);
        end else begin
          k_act_r <= cfg_write_data;
        end
      end
    end
  end

  // Read-pipe tags and result payload
  always_ff @(posedge clk) begin
    tl_d_r <= seq_r[LANE_W-1:0];
    ci_d_r <= seq_r;
    pj_d_r <= seq_r;
    if (state_r == ST_EMIT_CAP) begin
      out_idx_r  <= seq_r;
      out_rank_r <= rk_rdata;
      out_ovf_r  <= ovf_r;
      out_last_r <= seq_is_last;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_individual_index = out_idx_r;
  assign out_front_rank       = out_rank_r;
  assign out_overflow_seen    = out_ovf_r;
  assign out_last_result      = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_checker.sv =====
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks of the Pareto front ranker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_checker import pfr_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [IDX_W-1:0]     out_individual_index,
  input wire logic [RANK_W-1:0]    out_front_rank,
  input wire logic                 out_overflow_seen,
  input wire logic                 out_last_result
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_individual_index)
      && $stable(out_front_rank) && $stable(out_overflow_seen)
      && $stable(out_last_result))
    else $error("stalled result changed");

  // No new input transaction while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input open while a result is shown");

  // Every shown result carries a front number of at least one
  a_rank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_front_rank != '0)
    else $error("front rank of zero");

  // Mid-run transactions keep the input closed
  a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_result |=> in_stall)
    else $error("input opened before the last result");

  // After the last result the output goes quiet
  a_last_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_result |=> !out_valid)
    else $error("result after the last one");

endmodule

bind pareto_front_ranker_core pfr_checker u_pfr_checker (.*);

`default_nettype wire

// ===== bench/pfr_rank_checker.sv =====
// ----------------------------------------------------------------------------
// pfr_rank_checker
// Watches the load, result and configuration ports of the Pareto front ranker.
// It keeps its own copy of the loaded population and the objective count, and
// it ranks each population when its final individual is taken. Every result
// is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module pfr_rank_checker import pfr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic signed [31:0]   in_objective_a,
  input  logic signed [31:0]   in_objective_b,
  input  logic signed [31:0]   in_objective_c,
  input  logic signed [31:0]   in_objective_d,
  input  logic                 in_final_individual,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [IDX_W-1:0]     out_individual_index,
  input  logic [RANK_W-1:0]    out_front_rank,
  input  logic                 out_overflow_seen,
  input  logic                 out_last_result,
  input  logic                 cfg_write_en,
  input  logic [OBJ_CNT_W-1:0] cfg_write_data,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    idx_t  index;
    rank_t rank;
    logic  overflow;
    logic  last;
  } ranked_ind_t;

  obj_vec_t    population [POP_SIZE];
  int          loaded;
  bit          dropped_any;
  obj_cnt_t    objective_count;
  ranked_ind_t pending_ranks [$];

  // Out-of-range counts clamp: zero compares one objective, above four all four.
  function automatic int active_count();
    if (objective_count == 0) return 1;
    if (objective_count > NUM_OBJ) return NUM_OBJ;
    return int'(objective_count);
  endfunction

  function automatic bit beats(int a, int b, int k);
    bit strictly;
    strictly = 1'b0;
    for (int o = 0; o < k; o++) begin
      if (population[a][o] > population[b][o]) return 1'b0;
      if (population[a][o] < population[b][o]) strictly = 1'b1;
    end
    return strictly;
  endfunction

  // Non-dominated sort of the loaded individuals; queue one result each.
  function automatic void rank_population();
    pop_mask_t   dominated_set [POP_SIZE];
    int          dom_cnt [POP_SIZE];
    int          front_of [POP_SIZE];
    bit          in_front [POP_SIZE];
    int          k, n, front, ranked;
    ranked_ind_t r;
    k = active_count();
    n = loaded;
    for (int i = 0; i < POP_SIZE; i++) begin
      dominated_set[i] = '0;
      dom_cnt[i] = 0;
      front_of[i] = 0;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (i != j && beats(i, j, k)) begin
          dominated_set[i][j] = 1'b1;
          dom_cnt[j]++;
        end
      end
    end
    front = 1;
    ranked = 0;
    while (ranked < n) begin
      for (int i = 0; i < POP_SIZE; i++) begin
        in_front[i] = (i < n) && front_of[i] == 0 && dom_cnt[i] == 0;
        if (in_front[i]) begin
          front_of[i] = front;
          ranked++;
        end
      end
      // Peel the front off the dominator counts
      for (int i = 0; i < n; i++) begin
        if (in_front[i]) begin
          for (int j = 0; j < n; j++) begin
            if (dominated_set[i][j]) dom_cnt[j]--;
          end
        end
      end
      front++;
    end
    for (int i = 0; i < n; i++) begin
      r.index    = idx_t'(i);
      r.rank     = rank_t'(front_of[i]);
      r.overflow = dropped_any;
      r.last     = (i == n - 1);
      pending_ranks.insert(pending_ranks.size(), r);
    end
    loaded = 0;
    dropped_any = 1'b0;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    ranked_ind_t want;
    obj_vec_t    v;
    if (!rst_n) begin
      loaded = 0;
      dropped_any = 1'b0;
      objective_count = obj_cnt_t'(NUM_OBJ);
      pending_ranks.delete();
    end else begin
      if (cfg_write_en) objective_count = cfg_write_data;
      if (out_valid && !out_stall) begin
        if (pending_ranks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t unexpected result: idx %0d rank %0d ovf %0d last %0d", $realtime,
                     out_individual_index, out_front_rank, out_overflow_seen, out_last_result);
        end else begin
          want = pending_ranks.pop_front();
          if (out_individual_index !== want.index || out_front_rank !== want.rank ||
              out_overflow_seen !== want.overflow || out_last_result !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t result mismatch: expected idx %0d rank %0d ovf %0d last %0d, %s",
                       $realtime, want.index, want.rank, want.overflow, want.last,
                       $sformatf("got idx %0d rank %0d ovf %0d last %0d",
                                 out_individual_index, out_front_rank,
                                 out_overflow_seen, out_last_result));
          end
        end
      end
      if (in_valid && !in_stall) begin
        v[0] = in_objective_a;
        v[1] = in_objective_b;
        v[2] = in_objective_c;
        v[3] = in_objective_d;
        // Drop past capacity; a dropped final transaction still starts ranking
        if (loaded < POP_SIZE) begin
          population[loaded] = v;
          loaded++;
        end else begin
          dropped_any = 1'b1;
        end
        if (in_final_individual) rank_population();
      end
    end
    outstanding = pending_ranks.size();
  end

endmodule

// ===== bench/tb_pareto_front_ranker_core.sv =====
// ----------------------------------------------------------------------------
// tb_pareto_front_ranker_core
// Loads populations into the Pareto front ranker under random gaps and result
// stalls: a directed set of small fronts over every objective count, then
// random populations, among them a full dominance chain with overflow and a
// long result hold-off. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_pareto_front_ranker_core import pfr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   RANDOM_ITEMS   = 115;
  localparam int   CHAIN_POP      = 2;
  localparam int   SQUEEZE_POP    = 4;
  localparam int   SQUEEZE_CYCLES = 400;
  localparam int   SETTLE_CYCLES  = 8;
  localparam int   DRAIN_CYCLES   = 50;
  localparam int   WATCHDOG_LIMIT = 40000;
  localparam obj_t OBJ_MAX        = obj_t'(32'h7FFF_FFFF);
  localparam obj_t OBJ_MIN        = obj_t'(32'h8000_0000);

  typedef enum {VAL_NARROW, VAL_WIDE, VAL_EXTREME} value_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [31:0]   in_objective_a;
  logic signed [31:0]   in_objective_b;
  logic signed [31:0]   in_objective_c;
  logic signed [31:0]   in_objective_d;
  logic                 in_final_individual;
  logic                 out_valid;
  logic                 out_stall;
  logic [IDX_W-1:0]     out_individual_index;
  logic [RANK_W-1:0]    out_front_rank;
  logic                 out_overflow_seen;
  logic                 out_last_result;
  logic                 cfg_write_en;
  logic [OBJ_CNT_W-1:0] cfg_write_data;
  int                   mismatches;
  int                   outstanding;
  bit                   quiet_in;
  bit                   squeeze_armed;

  pareto_front_ranker_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_objective_a       (in_objective_a),
    .in_objective_b       (in_objective_b),
    .in_objective_c       (in_objective_c),
    .in_objective_d       (in_objective_d),
    .in_final_individual  (in_final_individual),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_individual_index (out_individual_index),
    .out_front_rank       (out_front_rank),
    .out_overflow_seen    (out_overflow_seen),
    .out_last_result      (out_last_result),
    .cfg_write_en         (cfg_write_en),
    .cfg_write_data       (cfg_write_data)
  );

  pfr_rank_checker ranking_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_objective_a       (in_objective_a),
    .in_objective_b       (in_objective_b),
    .in_objective_c       (in_objective_c),
    .in_objective_d       (in_objective_d),
    .in_final_individual  (in_final_individual),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_individual_index (out_individual_index),
    .out_front_rank       (out_front_rank),
    .out_overflow_seen    (out_overflow_seen),
    .out_last_result      (out_last_result),
    .cfg_write_en         (cfg_write_en),
    .cfg_write_data       (cfg_write_data),
    .mismatches           (mismatches),
    .outstanding          (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic obj_vec_t vec4(obj_t a, obj_t b, obj_t c, obj_t d);
    obj_vec_t v;
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = d;
    return v;
  endfunction

  function automatic obj_vec_t draw_vector(value_mode_t mode);
    obj_vec_t v;
    for (int o = 0; o < NUM_OBJ; o++) begin
      case (mode)
        VAL_NARROW: begin
          v[o] = obj_t'($urandom_range(0, 6)) - 3;
        end
        VAL_WIDE: begin
          v[o] = obj_t'($urandom);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: v[o] = OBJ_MAX;
            1: v[o] = OBJ_MIN;
            2: v[o] = '0;
            default: v[o] = -1;
          endcase
        end
      endcase
    end
    return v;
  endfunction

  // Offer one transaction after a random gap and hold it until taken.
  task automatic offer(obj_vec_t v, bit last_one);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_objective_a      <= v[0];
    in_objective_b      <= v[1];
    in_objective_c      <= v[2];
    in_objective_d      <= v[3];
    in_final_individual <= last_one;
    do @(posedge clk); while (in_stall);
  endtask

  // Write the objective count once the block has drained.
  task automatic set_objective_count(obj_cnt_t value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Result side: random stalls, quiet stretches, one long hold-off.
  initial begin
    int hold;
    bit took;
    bit quiet_out;
    hold = 0;
    quiet_out = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      if (squeeze_armed && out_valid) begin
        squeeze_armed = 1'b0;
        hold = SQUEEZE_CYCLES;
      end else if (took) begin
        if ($urandom_range(0, 19) == 0) quiet_out = !quiet_out;
        hold = quiet_out ? 0 : $urandom_range(0, 10);
      end
      @(negedge clk);
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int          random_items;
    int          pop;
    int          size;
    value_mode_t mode;
    obj_vec_t    chain_base;
    obj_vec_t    v;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_objective_a      = '0;
    in_objective_b      = '0;
    in_objective_c      = '0;
    in_objective_d      = '0;
    in_final_individual = 1'b0;
    cfg_write_en        = 1'b0;
    cfg_write_data      = '0;
    quiet_in            = 1'b0;
    squeeze_armed       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: lone individual, extreme vectors with a tie, each objective count
    set_objective_count(obj_cnt_t'(4));
    offer(vec4(OBJ_MAX, OBJ_MAX, OBJ_MAX, OBJ_MAX), 1'b1);
    offer(vec4(OBJ_MAX, OBJ_MAX, OBJ_MAX, OBJ_MAX), 1'b0);
    offer(vec4(OBJ_MIN, OBJ_MIN, OBJ_MIN, OBJ_MIN), 1'b0);
    offer(vec4(OBJ_MIN, OBJ_MIN, OBJ_MIN, OBJ_MIN), 1'b0);
    offer(vec4(OBJ_MIN, OBJ_MAX, 0, -1), 1'b1);
    set_objective_count(obj_cnt_t'(1));
    offer(vec4(5, OBJ_MIN, 9, 9), 1'b0);
    offer(vec4(5, OBJ_MAX, 0, 0), 1'b0);
    offer(vec4(-5, 0, 0, 0), 1'b1);
    // zero behaves as one objective
    set_objective_count(obj_cnt_t'(0));
    offer(vec4(0, 1, 2, 3), 1'b0);
    offer(vec4(1, 0, 0, 0), 1'b0);
    offer(vec4(0, 7, 7, 7), 1'b1);
    // seven clamps to four
    set_objective_count(obj_cnt_t'(7));
    offer(vec4(1, 2, 3, 4), 1'b0);
    offer(vec4(1, 2, 3, 3), 1'b0);
    offer(vec4(2, 1, 3, 4), 1'b1);
    set_objective_count(obj_cnt_t'(2));
    offer(vec4(1, 2, OBJ_MIN, OBJ_MIN), 1'b0);
    offer(vec4(2, 1, OBJ_MAX, OBJ_MAX), 1'b0);
    offer(vec4(1, 1, 0, 0), 1'b1);
    set_objective_count(obj_cnt_t'(3));
    offer(vec4(3, 3, 3, OBJ_MIN), 1'b0);
    offer(vec4(3, 3, 3, OBJ_MAX), 1'b0);
    offer(vec4(3, 3, 2, OBJ_MAX), 1'b1);

    random_items = 0;
    pop = 0;
    while (random_items < RANDOM_ITEMS) begin
      quiet_in = ($urandom_range(0, 3) == 0);
      // Skip the write after the hold-off so the next population backs up
      if (pop != SQUEEZE_POP + 1 && $urandom_range(0, 9) < 7)
        set_objective_count(obj_cnt_t'($urandom_range(0, 7)));
      if (pop == CHAIN_POP) begin
        // Each individual beats all before it: ranks 64 down to 1, then two dropped
        for (int o = 0; o < NUM_OBJ; o++) chain_base[o] = obj_t'($urandom_range(1000, 1000000));
        for (int i = 0; i < POP_SIZE + 2; i++) begin
          for (int o = 0; o < NUM_OBJ; o++) v[o] = chain_base[o] - obj_t'(i);
          offer(v, i == POP_SIZE + 1);
        end
        random_items += POP_SIZE;
      end else begin
        size = (pop == SQUEEZE_POP) ? 12 : $urandom_range(1, 12);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4:  mode = VAL_WIDE;
          5, 6, 7:        mode = VAL_EXTREME;
          default:        mode = VAL_NARROW;
        endcase
        if (pop == SQUEEZE_POP) squeeze_armed = 1'b1;
        for (int i = 0; i < size; i++) offer(draw_vector(mode), i == size - 1);
        random_items += size;
      end
      pop++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
